/* hw/rtl/dxtd_pkg.sv */
// Package for the DXT block decoder: palette types, constants and the
// constant-divide helpers used by the palette builder. No dependencies.

package dxtd_pkg;

	localparam int BLOCK_ROWS = 4;
	localparam int ALPHA_ENTRIES = 8;

	localparam logic [1:0] ROW_LAST = 2'd3;
	localparam logic [7:0] ALPHA_OPAQUE = 8'hFF;
	localparam logic [7:0] ALPHA_ZERO = 8'h00;
	localparam logic [23:0] COLOR_BLACK = 24'h000000;

	typedef enum logic {
		MODE_DXT1 = 1'b0,
		MODE_DXT5 = 1'b1
	} format_mode_t;

	// Four 888 color entries and eight alpha entries.
	typedef logic [3:0][23:0] color_pal_t;
	typedef logic [ALPHA_ENTRIES-1:0][7:0] alpha_pal_t;

	// Index fields of one block, split by row and column.
	typedef logic [BLOCK_ROWS-1:0][3:0][1:0] color_idx_t;
	typedef logic [BLOCK_ROWS-1:0][3:0][2:0] alpha_idx_t;

	// Truncating divide by 3 for x <= 765 via a scaled reciprocal.
	function automatic logic [7:0] div3(input logic [9:0] x);
		logic [20:0] p;
		p = 21'(x) * 21'(683);
		return p[18:11];
	endfunction

	// Truncating divide by 5 for x <= 1275.
	function automatic logic [7:0] div5(input logic [10:0] x);
		logic [21:0] p;
		p = 22'(x) * 22'(3277);
		return p[21:14];
	endfunction

	// Truncating divide by 7 for x <= 1785.
	function automatic logic [7:0] div7(input logic [10:0] x);
		logic [21:0] p;
		p = 22'(x) * 22'(2341);
		return p[21:14];
	endfunction

endpackage

/* hw/rtl/dxtd_palette.sv */
// Palette builder for the DXT block decoder: expands the color endpoints and
// interpolates the color and alpha palettes. Depends on dxtd_pkg.

module dxtd_palette import dxtd_pkg::*; (
	input  logic [63:0] color_word,
	input  logic [63:0] alpha_word,
	output color_pal_t  color_pal,
	output alpha_pal_t  alpha_pal
);

	logic [23:0] e0;
	logic [23:0] e1;
	logic [7:0]  a0;
	logic [7:0]  a1;

	// Endpoints are widened by shifting only, low bits stay zero.
	assign e0 = {color_word[15:11], 3'b000, color_word[10:5], 2'b00,
		color_word[4:0], 3'b000};
	assign e1 = {color_word[31:27], 3'b000, color_word[26:21], 2'b00,
		color_word[20:16], 3'b000};
	assign a0 = alpha_word[7:0];
	assign a1 = alpha_word[15:8];

	always_comb begin
		color_pal[0] = e0;
		color_pal[1] = e1;
		for (int c = 0; c < 3; c++) begin
			if (e0 > e1) begin
				color_pal[2][8*c +: 8] = div3(10'({e0[8*c +: 8], 1'b0}) + 10'(e1[8*c +: 8]));
				color_pal[3][8*c +: 8] = div3(10'(e0[8*c +: 8]) + 10'({e1[8*c +: 8], 1'b0}));
			end else begin
				color_pal[2][8*c +: 8] = 8'((9'(e0[8*c +: 8]) + 9'(e1[8*c +: 8])) >> 1);
				color_pal[3][8*c +: 8] = COLOR_BLACK[8*c +: 8];
			end
		end
	end

	always_comb begin
		alpha_pal[0] = a0;
		alpha_pal[1] = a1;
		if (a0 > a1) begin
			for (int k = 1; k <= 6; k++) begin
				alpha_pal[k+1] = div7(11'(7 - k) * 11'(a0) + 11'(k) * 11'(a1));
			end
		end else begin
			for (int k = 1; k <= 4; k++) begin
				alpha_pal[k+1] = div5(11'(5 - k) * 11'(a0) + 11'(k) * 11'(a1));
			end
			alpha_pal[6] = ALPHA_ZERO;
			alpha_pal[7] = ALPHA_OPAQUE;
		end
	end

endmodule

/* hw/rtl/dxt_block_decoder_unit.sv */
// Top level of the DXT block decoder: block register, row sequencing and the
// result register. Depends on dxtd_pkg and dxtd_palette.

// Each accepted request carries one compressed 4x4 block and yields four row
// results, row 0 first, one after another while the output is not stalled;
// the fourth carries tlast. The row sequencer over the single result channel
// paces the input: the next block is taken in the same cycle its predecessor's
// last row is loaded. A row is held in the result register before it appears
// on the output; a block passes through the block register, then each of its
// rows through the result register. format_mode selects DXT1 (alpha forced
// opaque) or DXT5 and must be written only while the block is idle.

module dxt_block_decoder_unit import dxtd_pkg::*; (
	input  logic         clk,
	input  logic         arst_n,
	input  logic         s_tvalid,
	output logic         s_tready,
	input  logic [127:0] s_tdata,  // color_word [63:0], alpha_word [127:64]
	output logic         m_tvalid,
	input  logic         m_tready,
	output logic [127:0] m_tdata,  // texel_zero, texel_one, texel_two, texel_three
	output logic [1:0]   m_tuser,  // row_index
	output logic         m_tlast,
	input  logic         cfg_valid,
	output logic         cfg_ready,
	input  logic         cfg_data
);

	format_mode_t mode_q;
	logic [63:0]  color_s1;
	logic [63:0]  alpha_s1;
	logic         valid_s1;
	logic [1:0]   row_q;
	logic         out_valid_q;
	logic [127:0] out_data_q;
	logic [1:0]   out_row_q;
	logic         out_last_q;

	logic         out_load;
	logic         in_take;
	color_pal_t   color_pal;
	alpha_pal_t   alpha_pal;
	color_idx_t   color_idx;
	alpha_idx_t   alpha_idx;
	logic [127:0] row_data;

	assign cfg_ready = 1'b1;
	assign out_load = valid_s1 && (!out_valid_q || m_tready);
	assign s_tready = !valid_s1 || (out_load && row_q == ROW_LAST);
	assign in_take = s_tvalid && s_tready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			mode_q <= MODE_DXT1;
		end else if (cfg_valid && cfg_ready) begin
			mode_q <= format_mode_t'(cfg_data);
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
			row_q <= 2'd0;
		end else begin
			if (in_take) begin
				valid_s1 <= 1'b1;
			end else if (out_load && row_q == ROW_LAST) begin
				valid_s1 <= 1'b0;
			end
			if (out_load) begin
				row_q <= row_q + 2'd1;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (in_take) begin
			color_s1 <= s_tdata[63:0];
			alpha_s1 <= s_tdata[127:64];
		end
	end

	dxtd_palette u_palette (
		.color_word (color_s1),
		.alpha_word (alpha_s1),
		.color_pal  (color_pal),
		.alpha_pal  (alpha_pal)
	);

	assign color_idx = color_s1[63:32];
	assign alpha_idx = alpha_s1[63:16];

	always_comb begin
		for (int n = 0; n < 4; n++) begin
			row_data[32*n +: 24] = color_pal[color_idx[row_q][n]];
			row_data[32*n+24 +: 8] = (mode_q == MODE_DXT5) ?
				alpha_pal[alpha_idx[row_q][n]] : ALPHA_OPAQUE;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (out_load) begin
			out_valid_q <= 1'b1;
		end else if (m_tready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (out_load) begin
			out_data_q <= row_data;
			out_row_q <= row_q;
			out_last_q <= (row_q == ROW_LAST);
		end
	end

	assign m_tvalid = out_valid_q;
	assign m_tdata = out_data_q;
	assign m_tuser = out_row_q;
	assign m_tlast = out_last_q;

`ifndef SYNTHESIS
	// A new block always starts its row sequence at the top row.
	a_start_row: assert property (@(posedge clk) disable iff (!arst_n)
		in_take |=> (valid_s1 && row_q == 2'd0))
		else $error("block accepted without restarting at row 0");

	// The row counter only moves while a block is held.
	a_row_held: assert property (@(posedge clk) disable iff (!arst_n)
		(row_q != 2'd0) |-> valid_s1)
		else $error("row counter off zero with no block held");

	// tlast marks exactly the bottom row.
	a_last_row: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid |-> (m_tlast == (m_tuser == ROW_LAST)))
		else $error("tlast does not match the row index");
`endif

endmodule

/* bench/tb.sv */
// Self-checking bench for dxt_block_decoder_unit: drives compressed blocks,
// predicts the four texel rows of each one and checks them in order.
// Depends on dxtd_pkg and the decoder RTL only.

module tb import dxtd_pkg::*;;

	timeunit 1ns;
	timeprecision 1ps;

	localparam int WATCHDOG_LIMIT = 2000;
	localparam int LONG_HOLD = 300;

	typedef struct packed {
		logic [1:0]       row;
		logic [3:0][31:0] texels;
		logic             last;
	} texel_row_t;

	class texel_scoreboard;
		texel_row_t rows_due[$];
		format_mode_t mode = MODE_DXT1;
		int errors = 0;

		function logic [23:0] widen_565(logic [15:0] e);
			return {e[15:11], 3'b000, e[10:5], 2'b00, e[4:0], 3'b000};
		endfunction

		function logic [23:0] mix_color(logic [23:0] c0, logic [23:0] c1,
				int unsigned w0, int unsigned w1, int unsigned dv);
			logic [23:0] res;
			int unsigned v;
			for (int ch = 0; ch < 3; ch++) begin
				v = (w0 * c0[ch*8 +: 8] + w1 * c1[ch*8 +: 8]) / dv;
				res[ch*8 +: 8] = v[7:0];
			end
			return res;
		endfunction

		// Builds both palettes of a block and queues its four rows.
		function void note_block(logic [63:0] cw, logic [63:0] aw);
			logic [3:0][23:0] colors;
			logic [7:0][7:0] alphas;
			int unsigned a0, a1;
			texel_row_t rr;
			logic [1:0] ci;
			logic [2:0] ai;
			logic [7:0] av;
			colors[0] = widen_565(cw[15:0]);
			colors[1] = widen_565(cw[31:16]);
			if (colors[0] > colors[1]) begin
				colors[2] = mix_color(colors[0], colors[1], 2, 1, 3);
				colors[3] = mix_color(colors[0], colors[1], 1, 2, 3);
			end else begin
				colors[2] = mix_color(colors[0], colors[1], 1, 1, 2);
				colors[3] = COLOR_BLACK;
			end
			a0 = aw[7:0];
			a1 = aw[15:8];
			alphas[0] = aw[7:0];
			alphas[1] = aw[15:8];
			if (a0 > a1) begin
				for (int unsigned k = 1; k <= 6; k++)
					alphas[k+1] = 8'(((7 - k) * a0 + k * a1) / 7);
			end else begin
				for (int unsigned k = 1; k <= 4; k++)
					alphas[k+1] = 8'(((5 - k) * a0 + k * a1) / 5);
				alphas[6] = ALPHA_ZERO;
				alphas[7] = ALPHA_OPAQUE;
			end
			for (int r = 0; r < 4; r++) begin
				rr.row = 2'(r);
				for (int n = 0; n < 4; n++) begin
					ci = cw[32 + 8*r + 2*n +: 2];
					ai = aw[16 + 12*r + 3*n +: 3];
					av = (mode == MODE_DXT5) ? alphas[ai] : ALPHA_OPAQUE;
					rr.texels[n] = {av, colors[ci]};
				end
				rr.last = (rr.row == ROW_LAST);
				rows_due.push_back(rr);
			end
		endfunction

		function void check_row(logic [1:0] row, logic [127:0] data, logic last);
			texel_row_t want;
			string names[4];
			logic [3:0][31:0] got;
			names = '{"texel_zero", "texel_one", "texel_two", "texel_three"};
			got = data;
			if (rows_due.size() == 0) begin
				$error("row result arrived with no block outstanding (row_index %0d)", row);
				errors++;
				return;
			end
			want = rows_due.pop_front();
			if (row !== want.row) begin
				$error("row_index: expected %0d, actual %0d", want.row, row);
				errors++;
			end
			for (int n = 0; n < 4; n++) begin
				if (got[n] !== want.texels[n]) begin
					$error("%s: expected %08h, actual %08h", names[n], want.texels[n],
						got[n]);
					errors++;
				end
			end
			if (last !== want.last) begin
				$error("last_row: expected %0b, actual %0b", want.last, last);
				errors++;
			end
		endfunction

		function int pending();
			return rows_due.size();
		endfunction
	endclass

	logic         clk = 1'b0;
	logic         arst_n = 1'b0;
	logic         s_tvalid = 1'b0;
	logic         s_tready;
	logic [127:0] s_tdata = '0;
	logic         m_tvalid;
	logic         m_tready = 1'b0;
	logic [127:0] m_tdata;
	logic [1:0]   m_tuser;
	logic         m_tlast;
	logic         cfg_valid = 1'b0;
	logic         cfg_ready;
	logic         cfg_data = 1'b0;

	texel_scoreboard sb = new();
	bit idle_on = 1'b1;
	bit hold_request = 1'b0;
	int hold_left = 0;
	int quiet_cycles = 0;

	dxt_block_decoder_unit dut (
		.clk(clk),
		.arst_n(arst_n),
		.s_tvalid(s_tvalid),
		.s_tready(s_tready),
		.s_tdata(s_tdata),
		.m_tvalid(m_tvalid),
		.m_tready(m_tready),
		.m_tdata(m_tdata),
		.m_tuser(m_tuser),
		.m_tlast(m_tlast),
		.cfg_valid(cfg_valid),
		.cfg_ready(cfg_ready),
		.cfg_data(cfg_data)
	);

	always #6 clk = ~clk;

	always @(posedge clk) begin
		if (arst_n && m_tvalid && m_tready)
			sb.check_row(m_tuser, m_tdata, m_tlast);
	end

	always @(posedge clk) begin
		if (!arst_n || (s_tvalid && s_tready) || (m_tvalid && m_tready) ||
				(cfg_valid && cfg_ready)) begin
			quiet_cycles = 0;
		end else begin
			quiet_cycles++;
			if (quiet_cycles >= WATCHDOG_LIMIT) begin
				$display("Some tests failed");
				$finish;
			end
		end
	end

	// Result side: random stalls, plus one long hold-off on request.
	initial begin
		forever begin
			@(posedge clk);
			if (hold_request) begin
				hold_request = 1'b0;
				hold_left = LONG_HOLD;
			end
			if (hold_left > 0) begin
				hold_left--;
				m_tready <= 1'b0;
			end else begin
				m_tready <= !(idle_on && $urandom_range(99) < 6);
			end
		end
	end

	task automatic send_block(logic [63:0] cw, logic [63:0] aw);
		while (idle_on && $urandom_range(99) < 6) begin
			s_tvalid <= 1'b0;
			@(posedge clk);
		end
		s_tvalid <= 1'b1;
		s_tdata <= {aw, cw};
		do @(posedge clk); while (!s_tready);
		sb.note_block(cw, aw);
	endtask

	task automatic drain();
		s_tvalid <= 1'b0;
		while (sb.pending() != 0)
			@(posedge clk);
	endtask

	task automatic write_mode(format_mode_t m);
		drain();
		cfg_valid <= 1'b1;
		cfg_data <= m;
		do @(posedge clk); while (!cfg_ready);
		cfg_valid <= 1'b0;
		sb.mode = m;
	endtask

	function automatic logic [63:0] alpha_block(logic [7:0] a0, logic [7:0] a1,
			logic [47:0] idx);
		return {idx, a1, a0};
	endfunction

	// Random block; equal endpoints and equal alphas show up now and then.
	task automatic send_random(int count);
		logic [63:0] cw, aw;
		repeat (count) begin
			cw = {$urandom, $urandom};
			aw = {$urandom, $urandom};
			if ($urandom_range(7) == 0)
				cw[31:16] = cw[15:0];
			if ($urandom_range(7) == 0)
				aw[15:8] = aw[7:0];
			send_block(cw, aw);
		end
	endtask

	initial begin
		repeat (10) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// Reset mode is DXT1: alpha bits must have no effect.
		send_block(64'h0, 64'h0);
		send_block('1, '1);
		send_block({32'hE4E4_E4E4, 16'h0000, 16'hFFFF}, {$urandom, $urandom});

		write_mode(MODE_DXT5);
		send_block(64'h0, 64'h0);
		send_block('1, '1);
		// Four-color block with the eight-entry alpha palette, every index used.
		send_block({32'hE4E4_E4E4, 16'h0000, 16'hFFFF},
			alpha_block(8'hFF, 8'h00, 48'o7654321076543210));
		// Three-color block with black, six-entry alpha with 0 and 255.
		send_block({32'h1B1B_1B1B, 16'hFFFF, 16'h0000},
			alpha_block(8'h00, 8'hFF, 48'o0123456701234567));
		send_block({32'hD872_8D27, 16'h7BEF, 16'h7BEF},
			alpha_block(8'h80, 8'h80, 48'o7070707012345670));
		send_block({32'hE4E4_E4E4, 16'h07E0, 16'hF800},
			alpha_block(8'hFF, 8'hFE, 48'o7654321076543210));
		send_block({32'hE4E4_E4E4, 16'hF800, 16'h07E0},
			alpha_block(8'h01, 8'h00, 48'o0123456776543210));
		send_block({32'hE4E4_E4E4, 16'h001F, 16'h0020},
			alpha_block(8'h00, 8'h01, 48'o7654321001234567));
		send_block({32'hE4E4_E4E4, 16'hFFDF, 16'hFFFF},
			alpha_block(8'hFE, 8'hFF, 48'o7654321076543210));
		// Each row with indices of its own.
		send_block({32'h00_55_AA_FF, 16'h1234, 16'hC3A5},
			alpha_block(8'hC0, 8'h30, 48'o0000_7777_2222_5555));
		send_block({32'hFF_AA_55_00, 16'hC3A5, 16'h1234},
			alpha_block(8'h30, 8'hC0, 48'o7777_0000_6666_1111));

		write_mode(MODE_DXT1);
		send_random(60);

		write_mode(MODE_DXT5);
		// No idling for a while; one long hold-off on the result side fills
		// the block while requests keep coming.
		idle_on = 1'b0;
		hold_request = 1'b1;
		send_random(40);
		idle_on = 1'b1;
		drain();
		send_random(60);

		write_mode(MODE_DXT1);
		send_random(20);
		write_mode(MODE_DXT5);
		send_random(20);

		drain();
		repeat (8) @(posedge clk);
		if (sb.errors == 0 && sb.pending() == 0)
			$display("All tests passed");
		else
			$display("Some tests failed");
		$finish;
	end

endmodule

/* dxt_block_decoder_unit.f */
hw/rtl/dxtd_pkg.sv
hw/rtl/dxtd_palette.sv
hw/rtl/dxt_block_decoder_unit.sv
bench/tb.sv
